/* src/rfid_reader_q_slot_controller_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the Q-slot controller
// Concurrent assertion shorthands shared by the RTL files that check themselves.
// ---------------------------------------------------------------------------
`ifndef RFID_READER_Q_SLOT_CONTROLLER_UNIT_MACROS_SVH
`define RFID_READER_Q_SLOT_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RQSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RQSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rqsc_pkg.sv */
// ---------------------------------------------------------------------------
// Q-slot controller package
// Types, codes and constants shared by the Q-slot controller modules.
// ---------------------------------------------------------------------------
package rqsc_pkg;

    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 144;
    localparam int OUTQ_DEPTH = 4;
    localparam int Q_TOP      = 15;

    localparam logic [31:0]       EPC_BROADCAST   = 32'hFFFF_FFFF;
    localparam logic signed [4:0] Q_STOPPED       = -5'sd1;
    localparam logic [15:0]       READER_ID_RESET = 16'd0;
    localparam logic signed [4:0] INITIAL_Q_RESET = 5'sd4;
    localparam logic [11:0]       INITIAL_QFP_RESET = 12'd1024;
    localparam logic [7:0]        STEP_C_RESET    = 8'd77;

    typedef enum logic [1:0] {
        FUNC_TAG_REPLY = 2'd0,
        FUNC_SLOT_END  = 2'd1,
        FUNC_START     = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CMD_QUERY      = 3'd0,
        CMD_QADJUST    = 3'd1,
        CMD_QREPLY_TAG = 3'd2,
        CMD_QREPLY_BC  = 3'd3,
        CMD_FINISHED   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        REG_READER_ID   = 2'd0,
        REG_INITIAL_Q   = 2'd1,
        REG_INITIAL_QFP = 2'd2,
        REG_STEP_C      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        func_t       func;
        logic        from_tag;
        logic [15:0] dest_reader;
        logic        is_standard;
        logic        is_final_reply;
        logic [31:0] reply_epc;
        logic [15:0] reply_rng;
    } item_t;

    typedef struct packed {
        cmd_t              cmd;
        logic signed [4:0] q_value;
        logic [31:0]       target_epc;
        logic [15:0]       target_rng;
        logic [15:0]       slot_total;
        logic [15:0]       collision_total;
        logic [15:0]       idle_total;
        logic [15:0]       success_total;
        logic [15:0]       session_no;
        logic              rearm_timer;
        logic signed [4:0] max_q;
        logic              last;
    } result_t;

    // Settings the core reads continuously.
    typedef struct packed {
        logic [15:0] reader_id;
        logic [7:0]  step_c;
    } cfg_t;

    // One-cycle loads of the Q state caused by register writes.
    typedef struct packed {
        logic              q_load;
        logic signed [4:0] q_val;
        logic              qfp_load;
        logic [11:0]       qfp_val;
    } cfg_load_t;

    // Results pushed into the output queue in one cycle; second implies first.
    typedef struct packed {
        logic first;
        logic second;
    } res_push_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

/* src/rqsc_cfg.sv */
// ---------------------------------------------------------------------------
// Q-slot controller register block
// APB-style register file holding reader identity, Q start values and step C.
// ---------------------------------------------------------------------------
module rqsc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rqsc_pkg::APB_AW-1:0]  paddr,
    input  logic [rqsc_pkg::APB_DW-1:0]  pwdata,
    output logic [rqsc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output rqsc_pkg::cfg_t               cfg,
    output rqsc_pkg::cfg_load_t          cfg_load
);
    import rqsc_pkg::*;

    logic [15:0]       reader_id_reg;
    logic signed [4:0] initial_q_reg;
    logic [11:0]       initial_qfp_reg;
    logic [7:0]        step_c_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reader_id_reg   <= READER_ID_RESET;
            initial_q_reg   <= INITIAL_Q_RESET;
            initial_qfp_reg <= INITIAL_QFP_RESET;
            step_c_reg      <= STEP_C_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_READER_ID:   reader_id_reg   <= pwdata[15:0];
                REG_INITIAL_Q:   initial_q_reg   <= $signed(pwdata[4:0]);
                REG_INITIAL_QFP: initial_qfp_reg <= pwdata[11:0];
                REG_STEP_C:      step_c_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_READER_ID:   prdata = APB_DW'(reader_id_reg);
            REG_INITIAL_Q:   prdata = APB_DW'($unsigned(initial_q_reg));
            REG_INITIAL_QFP: prdata = APB_DW'(initial_qfp_reg);
            REG_STEP_C:      prdata = APB_DW'(step_c_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.reader_id = reader_id_reg;
    assign cfg.step_c    = step_c_reg;

    // Writes of the start values load the live Q state at the same edge.
    assign cfg_load.q_load   = wr_en && (idx == REG_INITIAL_Q);
    assign cfg_load.q_val    = $signed(pwdata[4:0]);
    assign cfg_load.qfp_load = wr_en && (idx == REG_INITIAL_QFP);
    assign cfg_load.qfp_val  = pwdata[11:0];

endmodule

/* src/rqsc_core.sv */
// ---------------------------------------------------------------------------
// Q-slot controller core
// Input register, round state and the single-pass slot/Q update logic.
// ---------------------------------------------------------------------------
`include "rfid_reader_q_slot_controller_unit_macros.svh"

module rqsc_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rqsc_pkg::item_t     in_item,
    input  rqsc_pkg::cfg_t      cfg,
    input  rqsc_pkg::cfg_load_t cfg_load,
    input  logic                q_room,
    output rqsc_pkg::res_push_t push,
    output rqsc_pkg::result_t   res0,
    output rqsc_pkg::result_t   res1
);
    import rqsc_pkg::*;

    localparam int QW = FRAC_BITS + 4;
    localparam int LW = (QW > 12) ? QW : 12;
    localparam logic [QW-1:0] QFP_LIMIT = QW'(Q_TOP) << FRAC_BITS;
    localparam logic [QW:0]   QFP_HALF  = (QW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [QW-1:0] QFP_RESET =
        (LW'(INITIAL_QFP_RESET) > LW'(QFP_LIMIT)) ? QFP_LIMIT : QW'(INITIAL_QFP_RESET);

    function automatic logic signed [4:0] round_q(input logic [QW-1:0] x);
        logic [QW:0] s;
        s = {1'b0, x} + QFP_HALF;
        return $signed(5'(s >> FRAC_BITS));
    endfunction

    logic              in_valid_reg;
    item_t             item_reg;
    logic              advance;

    logic [1:0]        reply_count_reg, reply_count_next;
    logic [QW-1:0]     qfp_reg, qfp_next;
    logic signed [4:0] q_int_reg, q_int_next;
    logic signed [4:0] big_q_reg, big_q_next;
    logic [15:0]       slot_cnt_reg, slot_cnt_next;
    logic [15:0]       coll_cnt_reg, coll_cnt_next;
    logic [15:0]       idle_cnt_reg, idle_cnt_next;
    logic [15:0]       succ_cnt_reg, succ_cnt_next;
    logic [15:0]       session_cnt_reg, session_cnt_next;
    logic [31:0]       latched_epc_reg, latched_epc_next;
    logic [15:0]       latched_rng_reg, latched_rng_next;

    logic [QW:0]       qfp_sum;
    logic [QW-1:0]     qfp_cfg;
    logic signed [4:0] q_tmp;
    cmd_t              r0_cmd, r1_cmd;
    logic              r0_rearm, r1_rearm, r0_last, r0_to_tag;
    result_t           base;

    // The input register moves on whenever the queue can take two results.
    assign advance  = in_valid_reg && q_room;
    assign in_ready = !in_valid_reg || q_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    always_comb begin
        reply_count_next = reply_count_reg;
        qfp_next         = qfp_reg;
        q_int_next       = q_int_reg;
        big_q_next       = big_q_reg;
        slot_cnt_next    = slot_cnt_reg;
        coll_cnt_next    = coll_cnt_reg;
        idle_cnt_next    = idle_cnt_reg;
        succ_cnt_next    = succ_cnt_reg;
        session_cnt_next = session_cnt_reg;
        latched_epc_next = latched_epc_reg;
        latched_rng_next = latched_rng_reg;
        qfp_sum          = {1'b0, qfp_reg} + (QW + 1)'(cfg.step_c);
        q_tmp            = q_int_reg;
        r0_cmd           = CMD_QUERY;
        r1_cmd           = CMD_QREPLY_BC;
        r0_rearm         = 1'b0;
        r1_rearm         = 1'b0;
        r0_last          = 1'b1;
        r0_to_tag        = 1'b0;
        push.first       = 1'b0;
        push.second      = 1'b0;

        case (item_reg.func)
            FUNC_START: begin
                big_q_next       = q_int_reg;
                slot_cnt_next    = '0;
                coll_cnt_next    = '0;
                idle_cnt_next    = '0;
                succ_cnt_next    = '0;
                session_cnt_next = session_cnt_reg + 16'd1;
                r0_cmd           = CMD_QUERY;
                r0_rearm         = 1'b1;
                push.first       = advance;
            end
            FUNC_TAG_REPLY: begin
                if (item_reg.from_tag && item_reg.is_standard &&
                    (item_reg.dest_reader == cfg.reader_id)) begin
                    latched_epc_next = item_reg.reply_epc;
                    latched_rng_next = item_reg.reply_rng;
                    if (item_reg.is_final_reply) begin
                        reply_count_next = 2'd0;
                    end else if (reply_count_reg < 2'd2) begin
                        reply_count_next = reply_count_reg + 2'd1;
                    end
                end
            end
            FUNC_SLOT_END: begin
                slot_cnt_next = sat_inc16(slot_cnt_reg);
                push.first    = advance;
                if (reply_count_reg == 2'd0) begin
                    // Idle slot: Q falls by C; a stopped round stays stopped.
                    idle_cnt_next = sat_inc16(idle_cnt_reg);
                    qfp_next = (qfp_reg > QW'(cfg.step_c)) ? qfp_reg - QW'(cfg.step_c) : '0;
                    if (q_int_reg != Q_STOPPED) begin
                        q_tmp = round_q(qfp_next);
                        if (q_tmp >= big_q_reg) begin
                            big_q_next = q_tmp;
                        end
                    end
                    q_int_next = q_tmp;
                    if (q_tmp > 5'sd0) begin
                        r0_cmd   = CMD_QADJUST;
                        r0_rearm = 1'b1;
                    end else if (q_tmp == 5'sd0) begin
                        q_int_next = Q_STOPPED;
                        r0_cmd     = CMD_QADJUST;
                        r0_rearm   = 1'b1;
                    end else begin
                        r0_cmd = CMD_FINISHED;
                    end
                end else if (reply_count_reg == 2'd1) begin
                    succ_cnt_next    = sat_inc16(succ_cnt_reg);
                    reply_count_next = 2'd0;
                    r0_cmd           = CMD_QREPLY_TAG;
                    r0_to_tag        = 1'b1;
                    r0_last          = 1'b0;
                    r1_cmd           = CMD_QREPLY_BC;
                    r1_rearm         = 1'b1;
                    push.second      = advance;
                end else begin
                    // Collision: Q rises by C up to the top of the range.
                    coll_cnt_next    = sat_inc16(coll_cnt_reg);
                    reply_count_next = 2'd0;
                    qfp_next = (qfp_sum > {1'b0, QFP_LIMIT}) ? QFP_LIMIT : qfp_sum[QW-1:0];
                    q_tmp    = round_q(qfp_next);
                    q_int_next = q_tmp;
                    if (q_tmp >= big_q_reg) begin
                        big_q_next = q_tmp;
                    end
                    r0_cmd = CMD_QADJUST;
                    if (q_tmp == 5'(Q_TOP)) begin
                        r0_last     = 1'b0;
                        r1_cmd      = CMD_FINISHED;
                        push.second = advance;
                    end else begin
                        r0_rearm = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        base.cmd             = r0_cmd;
        base.q_value         = q_int_next;
        base.target_epc      = EPC_BROADCAST;
        base.target_rng      = '0;
        base.slot_total      = slot_cnt_next;
        base.collision_total = coll_cnt_next;
        base.idle_total      = idle_cnt_next;
        base.success_total   = succ_cnt_next;
        base.session_no      = session_cnt_next;
        base.rearm_timer     = r0_rearm;
        base.max_q           = big_q_next;
        base.last            = r0_last;

        res0 = base;
        if (r0_to_tag) begin
            res0.target_epc = latched_epc_reg;
            res0.target_rng = latched_rng_reg;
        end
        res1             = base;
        res1.cmd         = r1_cmd;
        res1.rearm_timer = r1_rearm;
        res1.last        = 1'b1;
    end

    assign qfp_cfg = (LW'(cfg_load.qfp_val) > LW'(QFP_LIMIT)) ? QFP_LIMIT
                                                                : QW'(cfg_load.qfp_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_count_reg <= '0;
            qfp_reg         <= QFP_RESET;
            q_int_reg       <= INITIAL_Q_RESET;
            big_q_reg       <= '0;
            slot_cnt_reg    <= '0;
            coll_cnt_reg    <= '0;
            idle_cnt_reg    <= '0;
            succ_cnt_reg    <= '0;
            session_cnt_reg <= '0;
        end else begin
            if (advance) begin
                reply_count_reg <= reply_count_next;
                big_q_reg       <= big_q_next;
                slot_cnt_reg    <= slot_cnt_next;
                coll_cnt_reg    <= coll_cnt_next;
                idle_cnt_reg    <= idle_cnt_next;
                succ_cnt_reg    <= succ_cnt_next;
                session_cnt_reg <= session_cnt_next;
            end
            // A register write of a start value takes priority over the round update.
            if (cfg_load.q_load) begin
                q_int_reg <= cfg_load.q_val;
            end else if (advance) begin
                q_int_reg <= q_int_next;
            end
            if (cfg_load.qfp_load) begin
                qfp_reg <= qfp_cfg;
            end else if (advance) begin
                qfp_reg <= qfp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_epc_reg <= '0;
            latched_rng_reg <= '0;
        end else if (advance) begin
            latched_epc_reg <= latched_epc_next;
            latched_rng_reg <= latched_rng_next;
        end
    end

    `RQSC_ASSERT_NOW(a_second_needs_first, aclk, aresetn, push.second, push.first,
        "second result pushed without a first")
    `RQSC_ASSERT_NOW(a_push_needs_item, aclk, aresetn, push.first,
        in_valid_reg && q_room, "result pushed without a held request")
    `RQSC_ASSERT_NEXT(a_reply_count_bound, aclk, aresetn, 1'b1,
        reply_count_reg != 2'd3, "reply count above saturation")

endmodule

/* src/rqsc_outq.sv */
// ---------------------------------------------------------------------------
// Q-slot controller result queue
// Small queue taking up to two results a cycle; one leaves on out_ready.
// ---------------------------------------------------------------------------
`include "rfid_reader_q_slot_controller_unit_macros.svh"

module rqsc_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  rqsc_pkg::res_push_t push,
    input  rqsc_pkg::result_t   d0,
    input  rqsc_pkg::result_t   d1,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output rqsc_pkg::result_t   out_res
);
    import rqsc_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    result_t         entry_reg [OUTQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;
    logic [CW-1:0]   n_push;

    assign pop    = out_valid && out_ready;
    assign n_push = CW'(push.first) + CW'(push.second);
    assign room   = count_reg <= CW'(OUTQ_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_res    = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + n_push - CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first) begin
            entry_reg[wr_ptr_reg] <= d0;
        end
        if (push.second) begin
            entry_reg[wr_ptr_reg + PW'(1)] <= d1;
        end
    end

    `RQSC_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(OUTQ_DEPTH),
        "result queue count beyond depth")
    `RQSC_ASSERT_NOW(a_no_overflow, aclk, aresetn, push.first,
        count_reg <= CW'(OUTQ_DEPTH - 2), "push into a queue without room")
    `RQSC_ASSERT_NEXT(a_hold_while_stalled, aclk, aresetn, out_valid && !out_ready,
        out_valid && $stable(rd_ptr_reg), "head result lost while stalled")

endmodule

/* src/rfid_reader_q_slot_controller_unit.sv */
// ---------------------------------------------------------------------------
// RFID reader Q-slot controller
// Reader side of a slotted inventory round: slot classing, Q adaptation
// and command generation.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         tvalid / tready    tuser: func; tdata: reply fields
//  m_        out        tvalid / tready    tuser: cmd; tdata: frame fields; tlast
//  apb       in/out     psel/penable       four registers at byte 0, 4, 8, 12
//
//  While s_tready is high, one request is taken per cycle; its results pass
//  from the input register into a four-entry queue and leave at one per cycle
//  while m_tready is high. Success slots and top-Q collisions give two results,
//  so the output port sets the sustained rate for such requests.
//  s_tready falls only while a request is held and the queue has under two
//  free entries. Reset clears the queue and loads the round state.
// ---------------------------------------------------------------------------
module rfid_reader_q_slot_controller_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // from_tag, dest_reader, is_standard, is_final_reply, reply_epc, reply_rng
    input  logic [rqsc_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // q_value, target_epc, target_rng, slot_total, collision_total, idle_total,
    // success_total, session_no, rearm_timer, max_q
    output logic [rqsc_pkg::M_TDATA_W-1:0] m_tdata,
    // cmd
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rqsc_pkg::APB_AW-1:0]    paddr,
    input  logic [rqsc_pkg::APB_DW-1:0]    pwdata,
    output logic [rqsc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import rqsc_pkg::*;

    cfg_t      cfg;
    cfg_load_t cfg_load;
    item_t     item;
    res_push_t push;
    result_t   res0, res1, out_res;
    logic      q_room;

    assign item.func           = func_t'(s_tuser);
    assign item.from_tag       = s_tdata[0];
    assign item.dest_reader    = s_tdata[16:1];
    assign item.is_standard    = s_tdata[17];
    assign item.is_final_reply = s_tdata[18];
    assign item.reply_epc      = s_tdata[50:19];
    assign item.reply_rng      = s_tdata[66:51];

    rqsc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .cfg_load (cfg_load)
    );

    rqsc_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .cfg      (cfg),
        .cfg_load (cfg_load),
        .q_room   (q_room),
        .push     (push),
        .res0     (res0),
        .res1     (res1)
    );

    rqsc_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .d0        (res0),
        .d1        (res1),
        .room      (q_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.cmd;
    assign m_tlast = out_res.last;
    assign m_tdata = {
        5'd0,
        out_res.max_q,
        out_res.rearm_timer,
        out_res.session_no,
        out_res.success_total,
        out_res.idle_total,
        out_res.collision_total,
        out_res.slot_total,
        out_res.target_rng,
        out_res.target_epc,
        out_res.q_value
    };

endmodule
